// ===== src/sfd_pkg.sv =====
package sfd_pkg;

    localparam int DELAY_DEPTH  = 65536;
    localparam int PTR_W        = $clog2(DELAY_DEPTH);
    localparam int SUM_W        = ((PTR_W > 16) ? PTR_W : 16) + 2;

    localparam int SMP_W        = 16;
    localparam int OUT_W        = 17;
    localparam int FB_W         = 15;
    localparam int WET_W        = 16;
    localparam int DLY_W        = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DAT_W    = 16;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 40;

    localparam int WET_FLOOR    = 4;
    localparam int FEEDBACK_MAX = 31130;
    localparam int WET_ONE      = 32768;
    localparam int DELAY_RESET  = 12000;
    localparam int RAMP_RESET   = 27;
    localparam int DELAY_MAX    = DELAY_DEPTH - 1;
    localparam int DELAY_INIT   = (DELAY_RESET > DELAY_MAX) ? DELAY_MAX : DELAY_RESET;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WET      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MONO     = 3'd4;

    typedef struct packed {
        logic             load;
        logic             rd_en;
        logic [PTR_W-1:0] rd_addr;
        logic             b_fwd;
        logic             b_bypass;
        logic             b_wr;
        logic [PTR_W-1:0] b_wr_addr;
        logic [WET_W-1:0] b_wet;
        logic             clr;
        logic [PTR_W-1:0] clr_addr;
    } t_lane_ctl;

endpackage

// ===== src/sfd_ram.sv =====
module sfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sfd_lane.sv =====
module sfd_lane (
    input  logic                                 i_clk,
    input  sfd_pkg::t_lane_ctl                   i_ctl,
    input  logic signed [sfd_pkg::SMP_W-1:0]     i_dry,
    input  logic        [sfd_pkg::FB_W-1:0]      i_fb,
    output logic signed [sfd_pkg::OUT_W-1:0]     o_result
);

    logic signed [sfd_pkg::SMP_W-1:0]  r_dry;
    logic signed [sfd_pkg::SMP_W-1:0]  r_last_wr;
    logic        [sfd_pkg::SMP_W-1:0]  ram_q;
    logic signed [sfd_pkg::SMP_W-1:0]  del;
    logic signed [31:0]                fb_prod;
    logic signed [31:0]                fb_rnd_full;
    logic signed [16:0]                fb_rnd;
    logic signed [17:0]                fb_sum;
    logic signed [sfd_pkg::SMP_W-1:0]  fb_sat;
    logic signed [32:0]                wet_prod;
    logic signed [32:0]                wet_rnd_full;
    logic signed [16:0]                wet_rnd;
    logic signed [sfd_pkg::OUT_W-1:0]  dry_ext;
    logic                              ram_we;
    logic [sfd_pkg::PTR_W-1:0]         ram_waddr;
    logic [sfd_pkg::SMP_W-1:0]         ram_wdata;

    // previous write is forwarded when it hits the address read in the same cycle
    assign del = i_ctl.b_fwd ? r_last_wr : $signed(ram_q);

    // feedback path: round half up to q1.15, then saturate
    assign fb_prod     = del * $signed({1'b0, i_fb});
    assign fb_rnd_full = (fb_prod + 32'sd16384) >>> 15;
    assign fb_rnd      = fb_rnd_full[16:0];
    assign fb_sum      = {{2{r_dry[15]}}, r_dry} + {fb_rnd[16], fb_rnd};

    always_comb begin
        if (fb_sum > 18'sd32767) begin
            fb_sat = 16'sh7fff;
        end else if (fb_sum < -18'sd32768) begin
            fb_sat = -16'sh8000;
        end else begin
            fb_sat = fb_sum[15:0];
        end
    end

    // wet path, kept at 17 bits
    assign wet_prod     = del * $signed({1'b0, i_ctl.b_wet});
    assign wet_rnd_full = (wet_prod + 33'sd16384) >>> 15;
    assign wet_rnd      = wet_rnd_full[16:0];
    assign dry_ext      = {r_dry[15], r_dry};

    assign o_result = i_ctl.b_bypass ? dry_ext : (dry_ext + wet_rnd);

    assign ram_we    = i_ctl.clr | i_ctl.b_wr;
    assign ram_waddr = i_ctl.clr ? i_ctl.clr_addr : i_ctl.b_wr_addr;
    assign ram_wdata = i_ctl.clr ? '0 : fb_sat;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_dry <= i_dry;
        end
        if (i_ctl.b_wr) begin
            r_last_wr <= fb_sat;
        end
    end

    sfd_ram #(
        .WIDTH (sfd_pkg::SMP_W),
        .DEPTH (sfd_pkg::DELAY_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_ctl.rd_en),
        .i_raddr (i_ctl.rd_addr),
        .o_rdata (ram_q)
    );

endmodule

// ===== src/stereo_feedback_delay.sv =====
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: in_left[15:0], in_right[31:16]
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: out_left[16:0], out_right[33:17], 0
// cfg       in   i_cfg_we                      i_cfg_idx, i_cfg_data
//
// one stereo pair per cycle when not clearing or stalled; transfers pass the compute stage
// into the output register; reset sweeps both delay rams to zero with s_axis_tready low
// a stalled output holds the compute stage; the next transfer in is still taken while the
// compute stage is empty or moving into a free or emptying output register
module stereo_feedback_delay (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // in_left, in_right
    input  logic [sfd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_left, out_right, zero fill
    output logic [sfd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sfd_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    logic [sfd_pkg::DLY_W-1:0]  r_delay;
    logic [sfd_pkg::FB_W-1:0]   r_fb;
    logic [sfd_pkg::WET_W-1:0]  r_wet_tgt;
    logic [sfd_pkg::WET_W-1:0]  r_ramp;
    logic                       r_mono;

    logic [sfd_pkg::PTR_W-1:0]  r_wi;
    logic [sfd_pkg::PTR_W-1:0]  n_wi;
    logic [sfd_pkg::WET_W-1:0]  r_wet;
    logic [sfd_pkg::WET_W-1:0]  n_wet;
    logic                       r_clr_busy;
    logic [sfd_pkg::PTR_W-1:0]  r_clr_idx;

    logic                       r_b_valid;
    logic                       r_b_bypass;
    logic                       r_b_fwd;
    logic [sfd_pkg::PTR_W-1:0]  r_b_wi;
    logic [sfd_pkg::WET_W-1:0]  r_b_wet;

    logic                       r_out_valid;
    logic signed [sfd_pkg::OUT_W-1:0] r_out_l;
    logic signed [sfd_pkg::OUT_W-1:0] r_out_r;

    logic                       accept;
    logic                       b_adv;
    logic                       b_wr;
    logic                       n_bypass;
    logic [sfd_pkg::WET_W-1:0]  gap;
    logic [sfd_pkg::WET_W-1:0]  step;
    logic [sfd_pkg::SUM_W-1:0]  rd_sum;
    logic [sfd_pkg::PTR_W-1:0]  rd_addr;
    logic signed [sfd_pkg::SMP_W-1:0] dry_l;
    logic signed [sfd_pkg::SMP_W-1:0] dry_r;
    logic signed [sfd_pkg::OUT_W-1:0] res_l;
    logic signed [sfd_pkg::OUT_W-1:0] res_r;
    sfd_pkg::t_lane_ctl         lane_ctl;

    assign b_adv         = !r_out_valid || m_axis_tready;
    assign b_wr          = r_b_valid && b_adv && !r_b_bypass;
    assign s_axis_tready = !r_clr_busy && (!r_b_valid || b_adv);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign dry_l = s_axis_tdata[15:0];
    assign dry_r = r_mono ? s_axis_tdata[15:0] : s_axis_tdata[31:16];

    // wet gain moves toward target by at most one ramp step
    always_comb begin
        gap   = '0;
        n_wet = r_wet;
        if (r_wet < r_wet_tgt) begin
            gap   = r_wet_tgt - r_wet;
            step  = (gap < r_ramp) ? gap : r_ramp;
            n_wet = r_wet + step;
        end else if (r_wet > r_wet_tgt) begin
            gap   = r_wet - r_wet_tgt;
            step  = (gap < r_ramp) ? gap : r_ramp;
            n_wet = r_wet - step;
        end else begin
            step  = '0;
        end
    end

    assign n_bypass = (32'(n_wet) < sfd_pkg::WET_FLOOR) && (n_wet == r_wet_tgt);

    always_comb begin
        rd_sum = sfd_pkg::SUM_W'(r_wi) + sfd_pkg::SUM_W'(sfd_pkg::DELAY_DEPTH)
                 - sfd_pkg::SUM_W'(r_delay);
        if (rd_sum >= sfd_pkg::SUM_W'(sfd_pkg::DELAY_DEPTH)) begin
            rd_sum = rd_sum - sfd_pkg::SUM_W'(sfd_pkg::DELAY_DEPTH);
        end
        rd_addr = rd_sum[sfd_pkg::PTR_W-1:0];
    end

    assign n_wi = (r_wi == sfd_pkg::PTR_W'(sfd_pkg::DELAY_DEPTH - 1)) ? '0 : r_wi + 1'b1;

    always_comb begin
        lane_ctl.load      = accept;
        lane_ctl.rd_en     = accept && !n_bypass;
        lane_ctl.rd_addr   = rd_addr;
        lane_ctl.b_fwd     = r_b_fwd;
        lane_ctl.b_bypass  = r_b_bypass;
        lane_ctl.b_wr      = b_wr;
        lane_ctl.b_wr_addr = r_b_wi;
        lane_ctl.b_wet     = r_b_wet;
        lane_ctl.clr       = r_clr_busy;
        lane_ctl.clr_addr  = r_clr_idx;
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay   <= sfd_pkg::DLY_W'(sfd_pkg::DELAY_INIT);
            r_fb      <= '0;
            r_wet_tgt <= '0;
            r_ramp    <= sfd_pkg::WET_W'(sfd_pkg::RAMP_RESET);
            r_mono    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sfd_pkg::CFG_DELAY: begin
                    if (i_cfg_data == '0) begin
                        r_delay <= sfd_pkg::DLY_W'(1);
                    end else if (32'(i_cfg_data) > sfd_pkg::DELAY_MAX) begin
                        r_delay <= sfd_pkg::DLY_W'(sfd_pkg::DELAY_MAX);
                    end else begin
                        r_delay <= i_cfg_data;
                    end
                end
                sfd_pkg::CFG_FEEDBACK: begin
                    if (32'(i_cfg_data[14:0]) > sfd_pkg::FEEDBACK_MAX) begin
                        r_fb <= sfd_pkg::FB_W'(sfd_pkg::FEEDBACK_MAX);
                    end else begin
                        r_fb <= i_cfg_data[14:0];
                    end
                end
                sfd_pkg::CFG_WET: begin
                    if (32'(i_cfg_data) > sfd_pkg::WET_ONE) begin
                        r_wet_tgt <= sfd_pkg::WET_W'(sfd_pkg::WET_ONE);
                    end else begin
                        r_wet_tgt <= i_cfg_data;
                    end
                end
                sfd_pkg::CFG_RAMP: begin
                    if (i_cfg_data == '0) begin
                        r_ramp <= sfd_pkg::WET_W'(1);
                    end else if (32'(i_cfg_data) > sfd_pkg::WET_ONE) begin
                        r_ramp <= sfd_pkg::WET_W'(sfd_pkg::WET_ONE);
                    end else begin
                        r_ramp <= i_cfg_data;
                    end
                end
                sfd_pkg::CFG_MONO: begin
                    r_mono <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wi        <= '0;
            r_wet       <= '0;
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
            r_b_valid   <= 1'b0;
            r_b_bypass  <= 1'b0;
            r_b_fwd     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == sfd_pkg::PTR_W'(sfd_pkg::DELAY_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (accept) begin
                r_wi       <= n_wi;
                r_wet      <= n_wet;
                r_b_bypass <= n_bypass;
                r_b_fwd    <= b_wr && (rd_addr == r_b_wi);
            end
            if (accept) begin
                r_b_valid <= 1'b1;
            end else if (b_adv) begin
                r_b_valid <= 1'b0;
            end
            if (b_adv) begin
                r_out_valid <= r_b_valid;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_wi  <= r_wi;
            r_b_wet <= n_wet;
        end
        if (b_adv && r_b_valid) begin
            r_out_l <= res_l;
            r_out_r <= res_r;
        end
    end

    sfd_lane u_lane_l (
        .i_clk    (i_clk),
        .i_ctl    (lane_ctl),
        .i_dry    (dry_l),
        .i_fb     (r_fb),
        .o_result (res_l)
    );

    sfd_lane u_lane_r (
        .i_clk    (i_clk),
        .i_ctl    (lane_ctl),
        .i_dry    (dry_r),
        .i_fb     (r_fb),
        .o_result (res_r)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_r, r_out_l};

endmodule

// ===== src/sfd_chk.sv =====
module sfd_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [sfd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    // the clearing sweep keeps the input closed right after reset
    a_reset_closed: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input ready right after reset");

    // a transfer in is followed by a valid output once the compute stage register is passed
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> ##1 m_axis_tvalid)
        else $error("result missing two cycles after transfer in");

    // a stalled result stays on the output, also while the input side is open
    a_no_dead_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready && s_axis_tready) |=> m_axis_tvalid)
        else $error("stalled result dropped");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind stereo_feedback_delay sfd_chk u_sfd_chk (.*);

// ===== tb/sfd_checker.sv =====
module sfd_checker
    import sfd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    // in_left, in_right
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    // out_left, out_right, zero fill
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DAT_W-1:0]   i_cfg_data,
    output int                     o_err_count,
    output int                     o_pending
);

    typedef struct packed {
        logic [OUT_W-1:0] right;
        logic [OUT_W-1:0] left;
    } t_stereo_out;

    logic signed [SMP_W-1:0] echo_l [DELAY_DEPTH];
    logic signed [SMP_W-1:0] echo_r [DELAY_DEPTH];
    int unsigned wr_ptr;
    int unsigned wet_now;
    int unsigned dly_len;
    int unsigned fb_gain;
    int unsigned wet_goal;
    int unsigned wet_step;
    logic        mono;
    t_stereo_out expected_pairs[$];
    int          errors = 0;

    // q.30 product to q.15, round half up
    function automatic int round_q15(input longint p);
        longint q;
        q = p + 16384;
        return int'(q >>> 15);
    endfunction

    function automatic logic signed [SMP_W-1:0] clamp_q15(input int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[SMP_W-1:0];
    endfunction

    task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        int unsigned v;
        v = 32'(data);
        case (idx)
            CFG_DELAY: begin
                if (v < 1) v = 1;
                if (v > DELAY_MAX) v = DELAY_MAX;
                dly_len = v;
            end
            CFG_FEEDBACK: begin
                v = v & 32'h7FFF;
                fb_gain = (v > FEEDBACK_MAX) ? FEEDBACK_MAX : v;
            end
            CFG_WET: wet_goal = (v > WET_ONE) ? WET_ONE : v;
            CFG_RAMP: begin
                if (v < 1) v = 1;
                if (v > WET_ONE) v = WET_ONE;
                wet_step = v;
            end
            CFG_MONO: mono = data[0];
            default: ;
        endcase
    endtask

    task automatic predict_echo(input logic [SMP_W-1:0] in_l, input logic [SMP_W-1:0] in_r);
        int          dry_l;
        int          dry_r;
        int          sum_l;
        int          sum_r;
        int          del_l;
        int          del_r;
        int unsigned rd;
        int unsigned gap;
        t_stereo_out e;
        dry_l = int'($signed(in_l));
        dry_r = mono ? dry_l : int'($signed(in_r));
        if (wet_now < wet_goal) begin
            gap = wet_goal - wet_now;
            wet_now += (gap < wet_step) ? gap : wet_step;
        end else if (wet_now > wet_goal) begin
            gap = wet_now - wet_goal;
            wet_now -= (gap < wet_step) ? gap : wet_step;
        end
        if (wet_now < WET_FLOOR && wet_now == wet_goal) begin
            // bypass: ring untouched, dry passes through
            sum_l = dry_l;
            sum_r = dry_r;
        end else begin
            rd    = (wr_ptr + DELAY_DEPTH - dly_len) % DELAY_DEPTH;
            del_l = int'(echo_l[rd]);
            del_r = int'(echo_r[rd]);
            echo_l[wr_ptr] = clamp_q15(dry_l + round_q15(longint'(del_l) * fb_gain));
            echo_r[wr_ptr] = clamp_q15(dry_r + round_q15(longint'(del_r) * fb_gain));
            sum_l = dry_l + round_q15(longint'(del_l) * wet_now);
            sum_r = dry_r + round_q15(longint'(del_r) * wet_now);
        end
        wr_ptr  = (wr_ptr + 1 == DELAY_DEPTH) ? 0 : wr_ptr + 1;
        e.left  = sum_l[OUT_W-1:0];
        e.right = sum_r[OUT_W-1:0];
        expected_pairs.push_back(e);
    endtask

    always @(posedge i_clk) begin : track
        t_stereo_out      e;
        logic [OUT_W-1:0] got_l;
        logic [OUT_W-1:0] got_r;
        got_l = i_m_tdata[OUT_W-1:0];
        got_r = i_m_tdata[2*OUT_W-1:OUT_W];
        if (!i_rst_n) begin
            for (int i = 0; i < DELAY_DEPTH; i++) begin
                echo_l[i] = '0;
                echo_r[i] = '0;
            end
            expected_pairs.delete();
            wr_ptr   = 0;
            wet_now  = 0;
            dly_len  = DELAY_INIT;
            fb_gain  = 0;
            wet_goal = 0;
            wet_step = RAMP_RESET;
            mono     = 1'b0;
        end else begin
            if (i_cfg_we) apply_cfg(i_cfg_idx, i_cfg_data);
            if (i_s_tvalid && i_s_tready)
                predict_echo(i_s_tdata[SMP_W-1:0], i_s_tdata[2*SMP_W-1:SMP_W]);
            if (i_m_tvalid && i_m_tready) begin
                if (expected_pairs.size() == 0) begin
                    $error("unexpected output transfer: out_left %0d out_right %0d",
                           $signed(got_l), $signed(got_r));
                    errors++;
                end else begin
                    e = expected_pairs.pop_front();
                    if (got_l !== e.left) begin
                        $error("out_left expected %0d got %0d", $signed(e.left), $signed(got_l));
                        errors++;
                    end
                    if (got_r !== e.right) begin
                        $error("out_right expected %0d got %0d", $signed(e.right), $signed(got_r));
                        errors++;
                    end
                end
            end
        end
        o_err_count <= errors;
        o_pending   <= expected_pairs.size();
    end

endmodule

// ===== tb/tb_stereo_feedback_delay.sv =====
module tb_stereo_feedback_delay;
    import sfd_pkg::*;

    localparam int STALL_LIMIT = 4 * DELAY_DEPTH;
    localparam int ITEM_TOTAL  = 1050;
    localparam int CALM_FROM   = 900;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DAT_W-1:0]   i_cfg_data;

    int err_count;
    int pending_pairs;
    int quiet_cycles = 0;
    int hold_cycles  = 0;
    int pairs_sent   = 0;
    bit idle_on      = 1'b1;

    stereo_feedback_delay DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    sfd_checker u_sfd_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_err_count (err_count),
        .o_pending   (pending_pairs)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // output side back-pressure in bursts of random length while idles are enabled
    always @(posedge i_clk) begin
        if (hold_cycles != 0) begin
            hold_cycles   <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            hold_cycles   <= int'($urandom_range(0, 8));
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("stereo_feedback_delay: mismatch");
            $finish;
        end
    end

    function automatic logic [SMP_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            default: return SMP_W'($urandom);
        endcase
    endfunction

    task automatic send_pair(input logic [SMP_W-1:0] left, input logic [SMP_W-1:0] right);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {right, left};
        do @(posedge i_clk); while (!s_axis_tready);
        pairs_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_pairs != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic load_regs(input logic [CFG_DAT_W-1:0] dly, input logic [CFG_DAT_W-1:0] fb,
                             input logic [CFG_DAT_W-1:0] wet, input logic [CFG_DAT_W-1:0] ramp,
                             input logic mono, input bit poke_unused);
        wait_drained();
        cfg_put(CFG_DELAY, dly);
        cfg_put(CFG_FEEDBACK, fb);
        cfg_put(CFG_WET, wet);
        cfg_put(CFG_RAMP, ramp);
        cfg_put(CFG_MONO, {15'd0, mono});
        // indexes past the register list must be ignored
        if (poke_unused)
            cfg_put(CFG_MONO + CFG_IDX_W'($urandom_range(1, 3)), CFG_DAT_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        logic [CFG_DAT_W-1:0] dly;
        logic [CFG_DAT_W-1:0] fb;
        logic [CFG_DAT_W-1:0] wet;
        logic [CFG_DAT_W-1:0] ramp;
        int                   burst;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: wet gain zero, so dry passes through
        send_pair(16'h8000, 16'h7FFF);
        send_pair(16'h7FFF, 16'h8000);
        send_pair(16'h0000, 16'hFFFF);
        send_pair(16'hFFFF, 16'h0000);

        // shortest delay, feedback and wet over range, full ramp step
        load_regs(16'h0000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
        send_pair(16'h7FFF, 16'h8000);
        send_pair(16'h7FFF, 16'h8000);
        send_pair(16'h8000, 16'h7FFF);
        send_pair(16'h8000, 16'h7FFF);
        send_pair(16'h0000, 16'h0000);
        send_pair(16'hFFFF, 16'h0001);
        send_pair(16'h7FFF, 16'h7FFF);

        // mono mode
        load_regs(16'd2, CFG_DAT_W'(FEEDBACK_MAX), CFG_DAT_W'(WET_ONE), 16'd1000, 1'b1, 1'b0);
        repeat (4) send_pair(pick_sample(), pick_sample());

        // wet gain settles below the floor: bypass
        load_regs(16'hFFFF, 16'd0, 16'd3, CFG_DAT_W'(WET_ONE), 1'b0, 1'b0);
        send_pair(16'h8000, 16'h7FFF);
        send_pair(16'h1234, 16'hEDCB);

        // ramp down by one to zero, then bypass
        load_regs(16'd1, CFG_DAT_W'(FEEDBACK_MAX), 16'd0, 16'd0, 1'b0, 1'b0);
        repeat (4) send_pair(pick_sample(), pick_sample());

        // wet gain exactly at the floor is not bypass
        load_regs(16'd1, 16'd100, CFG_DAT_W'(WET_FLOOR), CFG_DAT_W'(WET_ONE), 1'b1, 1'b0);
        repeat (2) send_pair(pick_sample(), pick_sample());

        while (pairs_sent < ITEM_TOTAL) begin
            case ($urandom_range(0, 4))
                0:       dly = 16'd0;
                1:       dly = CFG_DAT_W'($urandom_range(1, 16));
                2:       dly = CFG_DAT_W'($urandom_range(1, 600));
                3:       dly = CFG_DAT_W'($urandom);
                default: dly = 16'hFFFF;
            endcase
            case ($urandom_range(0, 3))
                0, 1:    fb = CFG_DAT_W'($urandom_range(0, 32767));
                2:       fb = CFG_DAT_W'(FEEDBACK_MAX);
                default: fb = CFG_DAT_W'($urandom_range(31000, 32767));
            endcase
            case ($urandom_range(0, 5))
                0:       wet = CFG_DAT_W'($urandom_range(0, WET_FLOOR));
                1:       wet = CFG_DAT_W'(WET_ONE);
                2:       wet = 16'hFFFF;
                default: wet = CFG_DAT_W'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       ramp = CFG_DAT_W'($urandom_range(0, 64));
                1:       ramp = CFG_DAT_W'($urandom);
                2:       ramp = 16'hFFFF;
                default: ramp = CFG_DAT_W'($urandom_range(1, 2000));
            endcase
            load_regs(dly, fb, wet, ramp, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
            burst = int'($urandom_range(30, 110));
            repeat (burst) begin
                if (pairs_sent >= CALM_FROM) idle_on = 1'b0;
                send_pair(pick_sample(), pick_sample());
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_pairs != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (err_count == 0)
            $display("stereo_feedback_delay: match");
        else
            $display("stereo_feedback_delay: mismatch");
        $finish;
    end

endmodule
